>>> rtl/bpa_pkg.sv
// shared types and constants of the bitmap page allocator
package bpa_pkg;

	localparam int JOB_W       = 4;
	localparam int PAGE_CNT_W  = 7;
	localparam int PAGE_IDX_W  = 6;
	localparam int BLK_W       = 10;
	localparam int STATUS_W    = 3;
	localparam int TOTAL_W     = 11;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_ADDR_W  = 3;
	localparam int JOB_IDS     = 2 ** JOB_W;

	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;

	// register index, taken from paddr[2]
	localparam logic REG_TOTAL_BLOCKS = 1'b0;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 3'd0,
		STATUS_SHORT    = 3'd1,
		STATUS_UNKNOWN  = 3'd2,
		STATUS_ACTIVE   = 3'd3,
		STATUS_BADCOUNT = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ALLOC,
		ST_FREE
	} state_t;

	typedef struct packed {
		logic                  kind;
		logic [JOB_W-1:0]      job_id;
		logic [PAGE_CNT_W-1:0] page_count;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [PAGE_IDX_W-1:0] page_index;
		logic [BLK_W-1:0]      block_number;
		logic [PAGE_CNT_W-1:0] freed_count;
		logic                  last;
	} rsp_t;

	// one entry of the block memory
	typedef struct packed {
		logic             used;
		logic [JOB_W-1:0] owner;
	} blk_entry_t;

	localparam int ENTRY_W = $bits(blk_entry_t);

endpackage

>>> rtl/bpa_ram.sv
// generic simple dual-port ram, one write port and one registered read port
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/bitmap_page_allocator.sv
// first-fit bitmap page allocator: block memory scan with owner tracking
//
//  channel   | ports                                     | flow
//  ----------+-------------------------------------------+---------------------------
//  request   | start, busy, req                          | taken when start & !busy
//  result    | rsp_valid, rsp                            | one cycle each, no stall
//  config    | psel, penable, pwrite, paddr, pwdata, ... | apb, pready tied high
//
// an error reply comes in the cycle after the request, busy stays low.
// allocate reads one block per cycle from block 0 and ends on the block of the
// last page, one result per page as found.
// free reads every block once and gives one result at the end.
// after reset and after each total_blocks write, a clearing pass writes all
// NUM_BLOCKS entries, one a cycle, with busy high; the block memory port sets it all.
module bitmap_page_allocator #(
	parameter int NUM_BLOCKS    = 1024,
	parameter int MAX_JOBS      = 16,
	parameter int MAX_JOB_PAGES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  bpa_pkg::req_t                  req,
	output logic                           rsp_valid,
	output bpa_pkg::rsp_t                  rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bpa_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [bpa_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [bpa_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);

	import bpa_pkg::*;

	localparam int AW = $clog2(NUM_BLOCKS);
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int TW = (CW > TOTAL_W) ? CW : TOTAL_W;
	localparam int MW = (CW > PAGE_CNT_W) ? CW : PAGE_CNT_W;
	localparam int NJ = (MAX_JOBS < JOB_IDS) ? MAX_JOBS : JOB_IDS;
	localparam int JW = $clog2(NJ);
	localparam logic [AW-1:0] LAST_BLK = AW'(NUM_BLOCKS - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(NUM_BLOCKS);
	localparam logic [CW-1:0] RESET_FREE =
		(NUM_BLOCKS < 1024) ? CW'(NUM_BLOCKS) : CW'(1024);

	state_t                state_q, state_d;
	logic [TOTAL_W-1:0]    total_q;
	logic [CW-1:0]         free_q;
	logic [NJ-1:0]         active_q;
	logic [AW-1:0]         clr_q;
	logic [AW-1:0]         ptr_q;
	logic [AW-1:0]         blk_s1;
	logic [JOB_W-1:0]      job_q;
	logic [PAGE_CNT_W-1:0] cnt_q;
	logic [PAGE_CNT_W-1:0] given_q;
	logic [PAGE_CNT_W-1:0] freed_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	logic                  cfg_wr;
	logic [TOTAL_W-1:0]    new_total;
	logic [CW-1:0]         new_free;
	logic                  acc;
	logic                  req_err;
	status_t               err_code;
	logic                  job_on;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	blk_entry_t            ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [ENTRY_W-1:0]    ram_rdata;
	blk_entry_t            entry;

	logic                  hit_alloc;
	logic                  alloc_done;
	logic                  hit_free;
	logic                  free_done;
	logic [PAGE_CNT_W-1:0] freed_total;

	// config port
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == REG_TOTAL_BLOCKS);
	assign new_total = pwdata[TOTAL_W-1:0];
	assign new_free  = (TW'(new_total) > TW'(NUM_BLOCKS)) ? FULL_CNT : CW'(new_total);
	assign prdata    = (paddr[2] == REG_TOTAL_BLOCKS) ? CFG_DATA_W'(total_q) : '0;

	// request decode
	assign acc    = start && (state_q == ST_IDLE);
	assign job_on = active_q[req.job_id[JW-1:0]];

	always_comb begin
		req_err  = 1'b1;
		err_code = STATUS_OK;
		if (32'(req.job_id) >= MAX_JOBS) begin
			err_code = STATUS_UNKNOWN;
		end else if (req.kind == KIND_ALLOC) begin
			if (req.page_count == '0 || req.page_count > PAGE_CNT_W'(MAX_JOB_PAGES)) begin
				err_code = STATUS_BADCOUNT;
			end else if (job_on) begin
				err_code = STATUS_ACTIVE;
			end else if (MW'(req.page_count) > MW'(free_q)) begin
				err_code = STATUS_SHORT;
			end else begin
				req_err = 1'b0;
			end
		end else begin
			if (!job_on) begin
				err_code = STATUS_UNKNOWN;
			end else begin
				req_err = 1'b0;
			end
		end
	end

	// scan datapath: the entry read last cycle is written back this cycle,
	// reads run strictly ahead so no two accesses meet on one entry
	assign entry       = blk_entry_t'(ram_rdata);
	assign hit_alloc   = (state_q == ST_ALLOC) && !entry.used;
	assign alloc_done  = hit_alloc && ((given_q + 1'b1) == cnt_q);
	assign hit_free    = (state_q == ST_FREE) && entry.used && (entry.owner == job_q);
	assign free_done   = (state_q == ST_FREE) && (blk_s1 == LAST_BLK);
	assign freed_total = freed_q + PAGE_CNT_W'(hit_free);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_BLK) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc && !req_err) state_d = (req.kind == KIND_FREE) ? ST_FREE : ST_ALLOC;
			end
			ST_ALLOC: begin
				if (alloc_done) state_d = ST_IDLE;
			end
			ST_FREE: begin
				if (free_done) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
		if (cfg_wr) state_d = ST_CLEAR;
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = ptr_q;
		ram_we    = 1'b0;
		ram_waddr = blk_s1;
		ram_wdata = '{used: 1'b0, owner: job_q};
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_re    = acc && !req_err;
				ram_raddr = '0;
			end
			ST_ALLOC: begin
				ram_re         = !alloc_done && (blk_s1 != LAST_BLK);
				ram_we         = hit_alloc;
				ram_wdata.used = 1'b1;
			end
			ST_FREE: begin
				ram_re = !free_done;
				ram_we = hit_free;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	bpa_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_BLOCKS)
	) u_blk_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			total_q     <= TOTAL_RESET;
			free_q      <= RESET_FREE;
			active_q    <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= 1'b0;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (acc && req_err) begin
				rsp_valid_q <= 1'b1;
			end
			if (hit_alloc) begin
				rsp_valid_q <= 1'b1;
			end
			if (alloc_done) begin
				free_q                  <= free_q - CW'(cnt_q);
				active_q[job_q[JW-1:0]] <= 1'b1;
			end
			if (free_done) begin
				rsp_valid_q             <= 1'b1;
				free_q                  <= free_q + CW'(freed_total);
				active_q[job_q[JW-1:0]] <= 1'b0;
			end
			// a total_blocks write starts over from an empty map
			if (cfg_wr) begin
				total_q  <= new_total;
				free_q   <= new_free;
				active_q <= '0;
				clr_q    <= '0;
			end
		end
	end

	// payload and scan registers
	always_ff @(posedge clk) begin
		if (acc) begin
			job_q   <= req.job_id;
			cnt_q   <= req.page_count;
			given_q <= '0;
			freed_q <= '0;
			ptr_q   <= AW'(1);
			blk_s1  <= '0;
			rsp_q   <= '{status: err_code, page_index: '0, block_number: '0,
				freed_count: '0, last: 1'b1};
		end
		if (state_q == ST_ALLOC || state_q == ST_FREE) begin
			ptr_q  <= ptr_q + 1'b1;
			blk_s1 <= ptr_q;
		end
		if (hit_alloc) begin
			given_q <= given_q + 1'b1;
			rsp_q   <= '{status: STATUS_OK, page_index: given_q[PAGE_IDX_W-1:0],
				block_number: BLK_W'(blk_s1), freed_count: '0, last: alloc_done};
		end
		if (state_q == ST_FREE) begin
			freed_q <= freed_total;
		end
		if (free_done) begin
			rsp_q <= '{status: STATUS_OK, page_index: '0, block_number: '0,
				freed_count: freed_total, last: 1'b1};
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// free count never exceeds the number of blocks
	assert property (@(posedge clk) disable iff (!arst_n) free_q <= FULL_CNT)
		else $error("free block count above block total");

	// the last page of an allocation ends the scan
	assert property (@(posedge clk) disable iff (!arst_n)
		(alloc_done && !cfg_wr) |=> (state_q == ST_IDLE && rsp_valid && rsp.last))
		else $error("allocation did not end on its last page");

	// an error reply is always a single result
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != STATUS_OK) |-> rsp.last)
		else $error("error reply not marked last");

	// no block memory writes from a scan while clearing
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (ram_we && ram_waddr == clr_q && !ram_re))
		else $error("clearing pass disturbed");

	// a free result reports at most one allocation's worth of blocks
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.freed_count != '0) |-> (rsp.freed_count <= PAGE_CNT_W'(MAX_JOB_PAGES)))
		else $error("free count above page limit");

endmodule
